// ===== sv/mma_pkg.sv =====
// ----------------------------------------------------------------------------
// mma_pkg
// shared codes and widths for the matrix multiply-accumulate unit
// ----------------------------------------------------------------------------
package mma_pkg;

  localparam int KIND_W     = 2;
  localparam int IDX_W      = 3;
  localparam int VAL_W      = 32;
  localparam int CNT_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;
  localparam int PROD_W     = 2 * VAL_W;

  typedef logic [KIND_W-1:0]    kind_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  localparam kind_t KIND_LOAD_A = 2'd0;
  localparam kind_t KIND_LOAD_B = 2'd1;
  localparam kind_t KIND_LOAD_C = 2'd2;
  localparam kind_t KIND_START  = 2'd3;

  localparam cfg_idx_t CFG_ROW_COUNT   = 3'd0;
  localparam cfg_idx_t CFG_INNER_COUNT = 3'd1;
  localparam cfg_idx_t CFG_COL_COUNT   = 3'd2;
  localparam cfg_idx_t CFG_TRANSPOSE_B = 3'd3;

  localparam cnt_t DIM_RESET = 4'd8;

endpackage

// ===== sv/matrix_multiply_accumulate_unit.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate_unit
// fixed-point C += A*B (or A*B^T) over three single-port-write stores
// ----------------------------------------------------------------------------
// load requests are accepted one per cycle while idle
// a start request emits row x col results in row-major order; each result
// passes through the single multiply-accumulate datapath (read, multiply,
// accumulate) fed from the A and B store read ports and may wait on any
// result-side stall; requests stall until the run ends
// reset clears control and output valid and sets the sizes to 8; store contents are not cleared
module matrix_multiply_accumulate_unit #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [mma_pkg::KIND_W-1:0]       in_kind,
  input  logic [mma_pkg::IDX_W-1:0]        in_row,
  input  logic [mma_pkg::IDX_W-1:0]        in_col,
  input  logic signed [mma_pkg::VAL_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mma_pkg::IDX_W-1:0]        out_row,
  output logic [mma_pkg::IDX_W-1:0]        out_col,
  output logic signed [mma_pkg::VAL_W-1:0] out_value,
  output logic                             out_last,
  input  logic                             cfg_we,
  input  logic [mma_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mma_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int VW    = mma_pkg::VAL_W;
  localparam int CW    = mma_pkg::CNT_W;
  localparam int PW    = mma_pkg::PROD_W;
  localparam int ACC_W = PW + CW;
  localparam int SUM_W = ACC_W + 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ELEM  = 2'd1;
  localparam logic [1:0] S_MAC   = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] rr,
                                            input logic [CW-1:0] cc);
    return AW'(rr) * AW'(MAX_DIM) + AW'(cc);
  endfunction

  function automatic logic [CW-1:0] clamp_dim(input logic [CW-1:0] d);
    return (32'(d) > MAX_DIM) ? CW'(MAX_DIM) : d;
  endfunction

  logic [VW-1:0] a_mem [DEPTH];
  logic [VW-1:0] b_mem [DEPTH];
  logic [VW-1:0] c_mem [DEPTH];

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] row_count_r, inner_count_r, col_count_r;
  logic          transpose_b_r;
  logic [CW-1:0] r_idx_r, c_idx_r, i_idx_r;
  logic [CW-1:0] nr, nk, nc;

  logic                 rd_vld_r, prod_vld_r;
  logic signed [VW-1:0] a_rd_r, b_rd_r, c_rd_r;
  logic signed [PW-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;

  logic          out_valid_r, out_last_r;
  logic [mma_pkg::IDX_W-1:0] out_row_r, out_col_r;
  logic [VW-1:0] out_value_r;

  logic          in_acc, load_ok, a_we, b_we, c_we, issue, finalize, slot_free, last_elem;
  logic [AW-1:0] ld_addr, a_addr, b_addr, c_addr, c_waddr;
  logic [VW-1:0] c_wdata, res;
  logic signed [ACC_W-1:0] acc_shift;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-VW:0] sum_hi;

  assign nr = clamp_dim(row_count_r);
  assign nk = clamp_dim(inner_count_r);
  assign nc = clamp_dim(col_count_r);

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign load_ok   = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
  assign ld_addr   = addr_of({1'b0, in_row}, {1'b0, in_col});
  assign a_we      = in_acc && load_ok && (in_kind == mma_pkg::KIND_LOAD_A);
  assign b_we      = in_acc && load_ok && (in_kind == mma_pkg::KIND_LOAD_B);

  assign slot_free = !out_valid_r || !out_stall;
  assign issue     = (state_r == S_MAC);
  assign finalize  = (state_r == S_DRAIN) && !rd_vld_r && !prod_vld_r && slot_free;
  assign last_elem = (r_idx_r == nr - CW'(1)) && (c_idx_r == nc - CW'(1));

  assign a_addr = addr_of(r_idx_r, i_idx_r);
  assign b_addr = transpose_b_r ? addr_of(c_idx_r, i_idx_r) : addr_of(i_idx_r, c_idx_r);
  assign c_addr = addr_of(r_idx_r, c_idx_r);

  // shift, add old element, saturate
  assign acc_shift = acc_r >>> FRAC_BITS;
  assign sum       = {acc_shift[ACC_W-1], acc_shift}
                   + {{(SUM_W-VW){c_rd_r[VW-1]}}, c_rd_r};
  assign sum_hi    = sum[SUM_W-1:VW-1];

  always_comb begin
    if ((&sum_hi) || !(|sum_hi)) begin
      res = sum[VW-1:0];
    end else if (sum[SUM_W-1]) begin
      res = {1'b1, {(VW-1){1'b0}}};
    end else begin
      res = {1'b0, {(VW-1){1'b1}}};
    end
  end

  assign c_we    = (in_acc && load_ok && (in_kind == mma_pkg::KIND_LOAD_C)) || finalize;
  assign c_waddr = finalize ? c_addr : ld_addr;
  assign c_wdata = finalize ? res : in_value;

  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[ld_addr] <= in_value;
    end
    a_rd_r <= a_mem[a_addr];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[ld_addr] <= in_value;
    end
    b_rd_r <= b_mem[b_addr];
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      c_mem[c_waddr] <= c_wdata;
    end
    if (state_r == S_ELEM) begin
      c_rd_r <= c_mem[c_addr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_kind == mma_pkg::KIND_START) && (nr != '0) && (nc != '0)) begin
          state_nxt = S_ELEM;
        end
      end
      S_ELEM: begin
        state_nxt = (nk == '0) ? S_DRAIN : S_MAC;
      end
      S_MAC: begin
        if (i_idx_r == nk - CW'(1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (finalize) begin
          state_nxt = last_elem ? S_IDLE : S_ELEM;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      row_count_r   <= mma_pkg::DIM_RESET;
      inner_count_r <= mma_pkg::DIM_RESET;
      col_count_r   <= mma_pkg::DIM_RESET;
      transpose_b_r <= 1'b0;
      rd_vld_r      <= 1'b0;
      prod_vld_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      r_idx_r       <= '0;
      c_idx_r       <= '0;
      i_idx_r       <= '0;
    end else begin
      state_r    <= state_nxt;
      rd_vld_r   <= issue;
      prod_vld_r <= rd_vld_r;

      if (cfg_we) begin
        case (cfg_index)
          mma_pkg::CFG_ROW_COUNT:   row_count_r   <= cfg_data;
          mma_pkg::CFG_INNER_COUNT: inner_count_r <= cfg_data;
          mma_pkg::CFG_COL_COUNT:   col_count_r   <= cfg_data;
          mma_pkg::CFG_TRANSPOSE_B: transpose_b_r <= cfg_data[0];
          default: ;
        endcase
      end

      if (state_r == S_IDLE) begin
        r_idx_r <= '0;
        c_idx_r <= '0;
      end
      if (state_r == S_ELEM) begin
        i_idx_r <= '0;
      end
      if (issue) begin
        i_idx_r <= i_idx_r + CW'(1);
      end
      if (finalize) begin
        if (c_idx_r == nc - CW'(1)) begin
          c_idx_r <= '0;
          r_idx_r <= r_idx_r + CW'(1);
        end else begin
          c_idx_r <= c_idx_r + CW'(1);
        end
      end

      if (finalize) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      prod_r <= a_rd_r * b_rd_r;
    end
    if (state_r == S_ELEM) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + {{(ACC_W-PW){prod_r[PW-1]}}, prod_r};
    end
    if (finalize) begin
      out_row_r   <= r_idx_r[mma_pkg::IDX_W-1:0];
      out_col_r   <= c_idx_r[mma_pkg::IDX_W-1:0];
      out_value_r <= res;
      out_last_r  <= last_elem;
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule
